[sv/sem_pkg.sv]
`timescale 1ns / 1ps

package sem_pkg;

	// Stack geometry.
	localparam int STACK_DEPTH = 32;
	localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int DIV_STEPS   = WORD_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	// Field widths of the item ports.
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;
	localparam int CHAR_W   = 7;

	// Operation codes carried by op.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_MOD   = 3'd1,
		OP_PCHAR = 3'd2,
		OP_PSTR  = 3'd3,
		OP_ROTL  = 3'd4,
		OP_ROTR  = 3'd5
	} op_t;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

	localparam logic [WORD_W-1:0] CHAR_MAX7 = WORD_W'(127);
	localparam logic [CHAR_W-1:0] NEWLINE   = CHAR_W'(10);

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD_B,
		S_MOD_A,
		S_MOD_RUN,
		S_PCHAR,
		S_EMIT_CHAR,
		S_PSTR_CHK,
		S_ROTL,
		S_ROTR,
		S_STATUS,
		S_NEWLINE
	} state_t;

	// Control handed to the remainder unit.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	// Slot one step below, wrapping at the bottom of the circular store.
	function automatic logic [IDX_W-1:0] idx_back1(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == '0) begin
			r = IDX_W'(STACK_DEPTH - 1);
		end else begin
			r = idx - IDX_W'(1);
		end
		return r;
	endfunction

	// Slot one step above, wrapping at the top of the circular store.
	function automatic logic [IDX_W-1:0] idx_fwd1(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == IDX_W'(STACK_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	// Slot n steps below, for n from 0 up to the depth itself.
	function automatic logic [IDX_W-1:0] idx_back_n(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] n);
		logic [CNT_W:0] wide_idx;
		logic [CNT_W:0] wide_n;
		logic [CNT_W:0] s;
		wide_idx = (CNT_W+1)'(idx);
		wide_n   = (CNT_W+1)'(n);
		if (wide_idx >= wide_n) begin
			s = wide_idx - wide_n;
		end else begin
			s = wide_idx + (CNT_W+1)'(STACK_DEPTH) - wide_n;
		end
		return IDX_W'(s);
	endfunction

	// Magnitude of a two's complement word, read as unsigned.
	function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
	endfunction

endpackage

[sv/stack_engine_mod_rotate_print_unit.sv]
`timescale 1ns / 1ps

// Stack engine with mod, print and rotate operations.
//
// Input channel (in_valid / in_ready) carries one operation item: op and
// push_value. Output channel (out_valid / out_ready) carries result items:
// status, has_char, char_code and last. Every operation yields at least one
// result item, and the final one of an operation has last set.
//
// The block works on one item at a time; in_ready is high only while the
// sequencer is idle. Mod relies on the restoring remainder unit, which
// retires one quotient bit per cycle. Pstr emits one character per cycle,
// while the receiver takes each item, from the single read port of the
// stack memory, plus the closing newline.
//
// Results go through an output register, so the last item of an operation
// may wait there while the next operation is accepted. When the receiver
// stalls, multi-item operations (pchar, pstr) pause until it takes the item.
// Reset empties the stack and drops any pending result; no clearing pass is
// needed since only live entries are ever read.
module stack_engine_mod_rotate_print_unit import sem_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          op,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic                     has_char,
	output logic [CHAR_W-1:0]        char_code,
	output logic                     last
);

	// Sequencer and stack control state.
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  top_q, top_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [CNT_W-1:0]  remain_q, remain_d;

	// Working payload registers.
	logic [STATUS_W-1:0] stat_q, stat_d;
	logic [CHAR_W-1:0]   char_q, char_d;
	logic [WORD_W-1:0]   b_q, b_d;
	logic                sign_q, sign_d;

	// Output register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_has_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;
	logic                out_load;
	logic [STATUS_W-1:0] out_status_d;
	logic                out_has_d;
	logic [CHAR_W-1:0]   out_char_d;
	logic                out_last_d;
	logic                out_free;

	// Stack memory ports.
	logic [WORD_W-1:0] mem [STACK_DEPTH];
	logic              mem_we;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data_q;

	// Remainder unit, used by mod.
	div_req_t          div_req;
	logic              div_done;
	logic [WORD_W-1:0] div_rem;

	logic in_accept;
	logic char_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign char_ok   = (rd_data_q != '0) && (rd_data_q <= CHAR_MAX7);

	sem_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		remain_q <= remain_d;
		stat_q   <= stat_d;
		char_q   <= char_d;
		b_q      <= b_d;
		sign_q   <= sign_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_has_q    <= out_has_d;
			out_char_q   <= out_char_d;
			out_last_q   <= out_last_d;
		end
	end

	// Next state, memory control and result item selection.
	always_comb begin
		state_d      = state_q;
		top_d        = top_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		remain_d     = remain_q;
		stat_d       = stat_q;
		char_d       = char_q;
		b_d          = b_q;
		sign_d       = sign_q;
		out_load     = 1'b0;
		out_status_d = ST_OK;
		out_has_d    = 1'b0;
		out_char_d   = '0;
		out_last_d   = 1'b1;
		mem_we       = 1'b0;
		wr_addr      = top_q;
		wr_data      = rd_data_q;
		rd_addr      = top_q;
		div_req      = '{start: 1'b0, dividend: magnitude(rd_data_q),
			divisor: magnitude(b_q)};

		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					stat_d  = ST_OK;
					state_d = S_STATUS;
					case (op)
						OP_PUSH: begin
							if (count_q >= CNT_W'(STACK_DEPTH)) begin
								stat_d = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								wr_addr = idx_fwd1(top_q);
								wr_data = push_value;
								top_d   = idx_fwd1(top_q);
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_MOD: begin
							if (count_q < CNT_W'(2)) begin
								stat_d = ST_SHORT;
							end else begin
								ptr_d   = idx_back1(top_q);
								state_d = S_MOD_B;
							end
						end
						OP_PCHAR: begin
							if (count_q == '0) begin
								stat_d = ST_EMPTY;
							end else begin
								state_d = S_PCHAR;
							end
						end
						OP_PSTR: begin
							ptr_d    = top_q;
							remain_d = count_q;
							if (count_q == '0) begin
								state_d = S_NEWLINE;
							end else begin
								state_d = S_PSTR_CHK;
							end
						end
						OP_ROTL: begin
							if (count_q >= CNT_W'(2)) begin
								state_d = S_ROTL;
							end
						end
						OP_ROTR: begin
							rd_addr = idx_back_n(top_q, count_q - CNT_W'(1));
							if (count_q >= CNT_W'(2)) begin
								state_d = S_ROTR;
							end
						end
						default: begin
							stat_d = ST_OK;
						end
					endcase
				end
			end
			S_MOD_B: begin
				// Read data holds the top entry, the divisor.
				b_d     = rd_data_q;
				rd_addr = ptr_q;
				state_d = S_MOD_A;
			end
			S_MOD_A: begin
				if (b_q == '0) begin
					stat_d  = ST_DIVZERO;
					state_d = S_STATUS;
				end else begin
					div_req.start = 1'b1;
					sign_d        = rd_data_q[WORD_W-1];
					state_d       = S_MOD_RUN;
				end
			end
			S_MOD_RUN: begin
				if (div_done) begin
					// The remainder takes the sign of the dividend.
					mem_we  = 1'b1;
					wr_addr = ptr_q;
					wr_data = sign_q ? (WORD_W'(0) - div_rem) : div_rem;
					top_d   = ptr_q;
					count_d = count_q - CNT_W'(1);
					stat_d  = ST_OK;
					state_d = S_STATUS;
				end
			end
			S_PCHAR: begin
				if (rd_data_q > CHAR_MAX7) begin
					stat_d  = ST_RANGE;
					state_d = S_STATUS;
				end else begin
					char_d  = rd_data_q[CHAR_W-1:0];
					state_d = S_EMIT_CHAR;
				end
			end
			S_EMIT_CHAR: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_has_d  = 1'b1;
					out_char_d = char_q;
					out_last_d = 1'b0;
					state_d    = S_NEWLINE;
				end
			end
			S_PSTR_CHK: begin
				// Hold the read address while stalled so the data stays put.
				rd_addr = ptr_q;
				if (!char_ok) begin
					state_d = S_NEWLINE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_has_d  = 1'b1;
					out_char_d = rd_data_q[CHAR_W-1:0];
					out_last_d = 1'b0;
					rd_addr    = idx_back1(ptr_q);
					ptr_d      = idx_back1(ptr_q);
					remain_d   = remain_q - CNT_W'(1);
					if (remain_q == CNT_W'(1)) begin
						state_d = S_NEWLINE;
					end
				end
			end
			S_ROTL: begin
				mem_we  = 1'b1;
				wr_addr = idx_back_n(top_q, count_q);
				top_d   = idx_back1(top_q);
				stat_d  = ST_OK;
				state_d = S_STATUS;
			end
			S_ROTR: begin
				mem_we  = 1'b1;
				wr_addr = idx_fwd1(top_q);
				top_d   = idx_fwd1(top_q);
				stat_d  = ST_OK;
				state_d = S_STATUS;
			end
			S_STATUS: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = stat_q;
					state_d      = S_IDLE;
				end
			end
			S_NEWLINE: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_has_d  = 1'b1;
					out_char_d = NEWLINE;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign has_char  = out_has_q;
	assign char_code = out_char_q;
	assign last      = out_last_q;

	// The stack never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("entry count above stack depth");

	// The top slot always lies inside the circular store.
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= IDX_W'(STACK_DEPTH - 1))
		else $error("top slot outside the store");

	// A push accepted with room grows the stack by exactly one entry.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (op == OP_PUSH) && (count_q < CNT_W'(STACK_DEPTH)))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not grow the stack");

	// The remainder unit only reports back while a mod is waiting for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_MOD_RUN))
		else $error("remainder finished outside a mod");

	// Character items always carry a good status.
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_has_q) |-> (out_status_q == ST_OK))
		else $error("character item with an error status");

endmodule

[sv/sem_div.sv]
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle.
module sem_div import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [WORD_W-1:0] remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W:0]   rem_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   trial;

	assign shifted = {rem_q[WORD_W-1:0], dvd_q[WORD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			if (trial[WORD_W]) begin
				rem_q <= shifted;
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[WORD_W-1:0];

endmodule
